>>> src/smalu_pkg.sv
// ---------------------------------------------------------------------------
// smalu_pkg
// Types and codes shared by the sign-magnitude Q32.32 ALU pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package smalu_pkg;

    localparam int WHOLE_W = 32;
    localparam int FRAC_W  = 32;
    localparam int MAG_W   = WHOLE_W + FRAC_W;
    localparam int OP_W    = 3;
    localparam int CMP_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_CMP = 3'd3,
        OP_NEG = 3'd4
    } op_t;

    // two's complement compare codes
    localparam logic [CMP_W-1:0] CMP_LESS    = 2'b11;
    localparam logic [CMP_W-1:0] CMP_EQUAL   = 2'b00;
    localparam logic [CMP_W-1:0] CMP_GREATER = 2'b01;

    typedef struct packed {
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
        logic               neg;
    } num_t;

    typedef struct packed {
        op_t  op;
        num_t left;
        num_t right;
    } req_t;

    // after stage 1: operands ordered for add, compare done, partial products
    typedef struct packed {
        op_t              op;
        logic [MAG_W-1:0] add_a;
        logic [MAG_W-1:0] add_b;
        logic             add_same;
        logic             add_neg;
        logic [CMP_W-1:0] cmp;
        num_t             neg_res;
        logic             mul_neg;
        logic [MAG_W-1:0] p00;
        logic [MAG_W-1:0] p01;
        logic [MAG_W-1:0] p10;
        logic [MAG_W-1:0] p11;
    } s1_t;

    // after stage 2: non-multiply result settled, product middle column summed
    typedef struct packed {
        logic               is_mul;
        logic [MAG_W-1:0]   res_mag;
        logic               res_neg;
        logic               ovf;
        logic [CMP_W-1:0]   cmp;
        logic [FRAC_W+1:0]  mid;
        logic [FRAC_W-1:0]  p01_hi;
        logic [FRAC_W-1:0]  p10_hi;
        logic [MAG_W-1:0]   p11;
        logic               unf;
        logic               mul_neg;
    } s2_t;

    typedef struct packed {
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
        logic               neg;
        logic               ovf;
        logic               unf;
        logic [CMP_W-1:0]   cmp;
    } alu_res_t;

endpackage

`default_nettype wire

>>> src/sign_magnitude_fixed_point_alu_unit.sv
// ---------------------------------------------------------------------------
// sign_magnitude_fixed_point_alu_unit
// Q32.32 sign-magnitude ALU: add, subtract, multiply, compare, negate.
// ---------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_axis    in   136    tdata: operands, tuser: operation code
//  m_axis    out  72     tdata: result magnitude, sign, flags, compare code
//
//  Three register stages; one request enters per clock while no stage is blocked.
//  Stage 1 holds the four 32x32 partial products, stage 2 the 65-bit
//  add/subtract, stage 3 the upper product column and the output register.
//  Each stage stalls only when it is full and the next one is blocked.
//  rst_n clears the stage valid bits; the data registers are not reset.
// ---------------------------------------------------------------------------
`default_nettype none

module sign_magnitude_fixed_point_alu_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // left_whole, left_frac, left_neg, right_whole, right_frac, right_neg, zero pad
    input  logic [135:0] s_axis_tdata,
    // req_type
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // res_whole, res_frac, res_neg, overflow, underflow, cmp_result, zero pad
    output logic [71:0]  m_axis_tdata
);
    import smalu_pkg::*;

    req_t     req;
    s1_t      s1_data;
    s2_t      s2_data;
    alu_res_t res;
    logic     s1_valid;
    logic     s1_ready;
    logic     s2_valid;
    logic     s2_ready;

    assign req.op          = op_t'(s_axis_tuser);
    assign req.left.whole  = s_axis_tdata[31:0];
    assign req.left.frac   = s_axis_tdata[63:32];
    assign req.left.neg    = s_axis_tdata[64];
    assign req.right.whole = s_axis_tdata[96:65];
    assign req.right.frac  = s_axis_tdata[128:97];
    assign req.right.neg   = s_axis_tdata[129];

    smalu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_req    (req),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    smalu_mid u_mid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    smalu_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    assign m_axis_tdata = {3'b000, res.cmp, res.unf, res.ovf, res.neg, res.frac, res.whole};

endmodule

`default_nettype wire

>>> src/smalu_front.sv
// ---------------------------------------------------------------------------
// smalu_front
// Stage 1: sign handling, magnitude compare, add operand ordering and the
// four 32x32 partial products.
// ---------------------------------------------------------------------------
`default_nettype none

module smalu_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  smalu_pkg::req_t  in_req,
    output logic             out_valid,
    input  logic             out_ready,
    output smalu_pkg::s1_t   out_data
);
    import smalu_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    s1_t              data_reg;
    s1_t              data_next;
    logic [MAG_W-1:0] lmag;
    logic [MAG_W-1:0] rmag;
    logic             l_zero;
    logic             r_zero;
    logic             mag_gt;
    logic             mag_eq;
    logic             r_eff_neg;
    logic [CMP_W-1:0] mag_cmp;
    logic [CMP_W-1:0] mag_cmp_inv;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign lmag   = {in_req.left.whole, in_req.left.frac};
    assign rmag   = {in_req.right.whole, in_req.right.frac};
    assign l_zero = (lmag == '0);
    assign r_zero = (rmag == '0);
    assign mag_gt = (lmag > rmag);
    assign mag_eq = (lmag == rmag);

    assign mag_cmp     = mag_gt ? CMP_GREATER : (mag_eq ? CMP_EQUAL : CMP_LESS);
    assign mag_cmp_inv = mag_gt ? CMP_LESS : (mag_eq ? CMP_EQUAL : CMP_GREATER);

    // subtract flips the right sign; a zero right operand becomes positive
    assign r_eff_neg = (in_req.op == OP_SUB) ? !(in_req.right.neg || r_zero)
                                             : in_req.right.neg;

    always_comb
    begin
        data_next          = data_reg;
        data_next.op       = in_req.op;
        data_next.add_same = (in_req.left.neg == r_eff_neg);
        if (in_req.left.neg == r_eff_neg || mag_gt)
        begin
            data_next.add_a   = lmag;
            data_next.add_b   = rmag;
            data_next.add_neg = in_req.left.neg;
        end
        else
        begin
            data_next.add_a   = rmag;
            data_next.add_b   = lmag;
            data_next.add_neg = r_eff_neg;
        end

        if (in_req.left.neg == in_req.right.neg)
            data_next.cmp = in_req.left.neg ? mag_cmp_inv : mag_cmp;
        else
            data_next.cmp = in_req.left.neg ? CMP_LESS : CMP_GREATER;

        data_next.neg_res     = in_req.left;
        data_next.neg_res.neg = !(in_req.left.neg || l_zero);
        data_next.mul_neg     = in_req.left.neg ^ in_req.right.neg;

        data_next.p00 = MAG_W'(in_req.left.frac)  * MAG_W'(in_req.right.frac);
        data_next.p01 = MAG_W'(in_req.left.frac)  * MAG_W'(in_req.right.whole);
        data_next.p10 = MAG_W'(in_req.left.whole) * MAG_W'(in_req.right.frac);
        data_next.p11 = MAG_W'(in_req.left.whole) * MAG_W'(in_req.right.whole);
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

>>> src/smalu_mid.sv
// ---------------------------------------------------------------------------
// smalu_mid
// Stage 2: magnitude add/subtract, selection of the non-multiply results and
// the middle column of the product.
// ---------------------------------------------------------------------------
`default_nettype none

module smalu_mid
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  smalu_pkg::s1_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output smalu_pkg::s2_t  out_data
);
    import smalu_pkg::*;

    logic           valid_reg;
    logic           valid_next;
    s2_t            data_reg;
    s2_t            data_next;
    logic [MAG_W:0] sum;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // same signs add, different signs take the smaller from the larger
    assign sum = {1'b0, in_data.add_a}
               + {1'b0, (in_data.add_same ? in_data.add_b : ~in_data.add_b)}
               + (MAG_W+1)'(!in_data.add_same);

    always_comb
    begin
        data_next         = data_reg;
        data_next.is_mul  = 1'b0;
        data_next.res_mag = '0;
        data_next.res_neg = 1'b0;
        data_next.ovf     = 1'b0;
        data_next.cmp     = CMP_EQUAL;
        unique case (in_data.op)
            OP_ADD, OP_SUB:
            begin
                data_next.res_mag = sum[MAG_W-1:0];
                data_next.res_neg = in_data.add_neg;
                data_next.ovf     = in_data.add_same && sum[MAG_W];
            end
            OP_MUL:
                data_next.is_mul = 1'b1;
            OP_CMP:
                data_next.cmp = in_data.cmp;
            OP_NEG:
            begin
                data_next.res_mag = {in_data.neg_res.whole, in_data.neg_res.frac};
                data_next.res_neg = in_data.neg_res.neg;
            end
            default:
            begin
                data_next.is_mul = 1'b0;
            end
        endcase

        data_next.mid     = (FRAC_W+2)'(in_data.p00[MAG_W-1:FRAC_W])
                          + (FRAC_W+2)'(in_data.p01[FRAC_W-1:0])
                          + (FRAC_W+2)'(in_data.p10[FRAC_W-1:0]);
        data_next.p01_hi  = in_data.p01[MAG_W-1:FRAC_W];
        data_next.p10_hi  = in_data.p10[MAG_W-1:FRAC_W];
        data_next.p11     = in_data.p11;
        data_next.unf     = |in_data.p00[FRAC_W-1:0];
        data_next.mul_neg = in_data.mul_neg;
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

>>> src/smalu_back.sv
// ---------------------------------------------------------------------------
// smalu_back
// Stage 3: upper product column, overflow check, zero sign cleanup and the
// output register.
// ---------------------------------------------------------------------------
`default_nettype none

module smalu_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  smalu_pkg::s2_t       in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output smalu_pkg::alu_res_t  out_data
);
    import smalu_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    alu_res_t          data_reg;
    alu_res_t          data_next;
    logic [FRAC_W+1:0] high;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign high = (FRAC_W+2)'(in_data.p01_hi)
                + (FRAC_W+2)'(in_data.p10_hi)
                + (FRAC_W+2)'(in_data.p11[FRAC_W-1:0])
                + (FRAC_W+2)'(in_data.mid[FRAC_W+1:FRAC_W]);

    always_comb
    begin
        data_next = data_reg;
        if (in_data.is_mul)
        begin
            data_next.whole = high[WHOLE_W-1:0];
            data_next.frac  = in_data.mid[FRAC_W-1:0];
            data_next.neg   = in_data.mul_neg;
            data_next.ovf   = (|in_data.p11[MAG_W-1:FRAC_W]) || (|high[FRAC_W+1:FRAC_W]);
            data_next.unf   = in_data.unf;
            data_next.cmp   = CMP_EQUAL;
        end
        else
        begin
            data_next.whole = in_data.res_mag[MAG_W-1:FRAC_W];
            data_next.frac  = in_data.res_mag[FRAC_W-1:0];
            data_next.neg   = in_data.res_neg;
            data_next.ovf   = in_data.ovf;
            data_next.unf   = 1'b0;
            data_next.cmp   = in_data.cmp;
        end
        // zero is never negative
        if (data_next.whole == '0 && data_next.frac == '0)
            data_next.neg = 1'b0;
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire
